// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/hklp_pkg.sv -----
// shared constants, types and the fnv-1a fold for the hashed key table
`timescale 1ns / 1ps

package hklp_pkg;

    // table depth is a power of two, so the home slot is the low hash bits
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int VALUE_BITS  = 32;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // one finished key waiting for the table
    typedef struct packed {
        logic                  req_type;
        logic [63:0]           digest;
        logic [VALUE_BITS-1:0] value;
    } job_t;

    typedef struct packed {
        logic                  valid;
        logic [63:0]           digest;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    // xor the sign-extended byte, then multiply by 2^40 + 0x1b3 as shifts and adds
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {{56{b[7]}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ----- rtl/core/hklp_front.sv -----
// front end: takes key bytes, folds the running hash, queues finished keys
`timescale 1ns / 1ps

module hklp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [7:0]                      key_byte,
    input  logic                            byte_present,
    input  logic                            key_last,
    input  logic [31:0]                     value_in,
    input  logic                            q_full,
    input  logic                            clearing,
    output logic                            push,
    output hklp_pkg::job_t                  push_job
);

    logic [63:0] running_hash_reg;
    logic [63:0] running_hash_next;
    logic [63:0] hash_folded;
    logic        accept;

    assign in_stall    = q_full || clearing;
    assign accept      = in_valid && !in_stall;
    assign hash_folded = byte_present ? hklp_pkg::fnv_fold(running_hash_reg, key_byte)
                                      : running_hash_reg;

    assign push              = accept && key_last;
    assign push_job.req_type = req_type;
    assign push_job.digest   = hash_folded;
    assign push_job.value    = hklp_pkg::VALUE_BITS'(value_in);

    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = key_last ? hklp_pkg::FNV_BASIS : hash_folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= hklp_pkg::FNV_BASIS;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule

// ----- rtl/core/hklp_queue.sv -----
// two-entry job queue between the hashing front end and the table back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hklp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hklp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output hklp_pkg::job_t head
);

    hklp_pkg::job_t entries_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, count_reg != 2'd2)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, count_reg != 2'd0)
    `ASSERT_NEXT(a_count_track, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1)

endmodule

// ----- rtl/core/hklp_back.sv -----
// back end: slot memory, clearing pass, linear probe sequencer, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hklp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  hklp_pkg::job_t q_job,
    output logic           q_pop,
    output logic           clearing,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status,
    output logic [31:0]    value_out,
    output logic [63:0]    key_digest
);

    localparam logic [hklp_pkg::CNT_BITS-1:0] FULL_COUNT =
        hklp_pkg::CNT_BITS'(hklp_pkg::TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } state_t;

    hklp_pkg::slot_t mem [hklp_pkg::TABLE_DEPTH];
    hklp_pkg::slot_t rd_slot_reg;

    logic                          mem_we;
    logic [hklp_pkg::IDX_BITS-1:0] mem_wa;
    hklp_pkg::slot_t               mem_wd;
    logic [hklp_pkg::IDX_BITS-1:0] rd_addr;

    state_t                        state_reg;
    state_t                        state_next;
    logic [hklp_pkg::IDX_BITS-1:0] clr_idx_reg;
    logic [hklp_pkg::IDX_BITS-1:0] clr_idx_next;
    logic [hklp_pkg::IDX_BITS-1:0] probe_idx_reg;
    logic [hklp_pkg::IDX_BITS-1:0] probe_idx_next;
    logic [hklp_pkg::IDX_BITS-1:0] probe_cnt_reg;
    logic [hklp_pkg::IDX_BITS-1:0] probe_cnt_next;
    hklp_pkg::job_t                job_reg;
    hklp_pkg::job_t                job_next;
    logic [hklp_pkg::CNT_BITS-1:0] entry_count_reg;
    logic [hklp_pkg::CNT_BITS-1:0] entry_count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    hklp_pkg::status_t             out_status_reg;
    hklp_pkg::status_t             out_status_next;
    logic [31:0]                   out_value_reg;
    logic [31:0]                   out_value_next;
    logic [63:0]                   out_hash_reg;
    logic [63:0]                   out_hash_next;

    assign clearing   = (state_reg == S_CLEAR);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign value_out  = out_value_reg;
    assign key_digest = out_hash_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        probe_idx_next   = probe_idx_reg;
        probe_cnt_next   = probe_cnt_reg;
        job_next         = job_reg;
        entry_count_next = entry_count_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        out_hash_next    = out_hash_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = probe_idx_reg;
        mem_wd           = '0;
        // while probing, the next slot is always fetched ahead of its check
        rd_addr          = probe_idx_reg + 1'b1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = q_job.digest[hklp_pkg::IDX_BITS-1:0];
                // a new job starts only once the previous result has been taken
                if (q_valid && !out_valid_reg)
                begin
                    q_pop          = 1'b1;
                    job_next       = q_job;
                    probe_idx_next = q_job.digest[hklp_pkg::IDX_BITS-1:0];
                    probe_cnt_next = '0;
                    if (q_job.req_type == hklp_pkg::REQ_INSERT && entry_count_reg == FULL_COUNT)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = hklp_pkg::ST_FULL;
                        out_value_next  = '0;
                        out_hash_next   = q_job.digest;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                out_hash_next  = job_reg.digest;
                out_value_next = '0;
                probe_idx_next = probe_idx_reg + 1'b1;
                probe_cnt_next = probe_cnt_reg + 1'b1;
                if (job_reg.req_type == hklp_pkg::REQ_INSERT)
                begin
                    if (!rd_slot_reg.valid)
                    begin
                        mem_we           = 1'b1;
                        mem_wd.valid     = 1'b1;
                        mem_wd.digest    = job_reg.digest;
                        mem_wd.value     = job_reg.value;
                        entry_count_next = entry_count_reg + 1'b1;
                        out_valid_next   = 1'b1;
                        out_status_next  = hklp_pkg::ST_INSERTED;
                        state_next       = S_IDLE;
                    end
                end
                else if (!rd_slot_reg.valid)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = hklp_pkg::ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else if (rd_slot_reg.digest == job_reg.digest)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = hklp_pkg::ST_FOUND;
                    out_value_next  = 32'(rd_slot_reg.value);
                    state_next      = S_IDLE;
                end
                else if (probe_cnt_reg == '1)
                begin
                    // every slot visited without a match
                    out_valid_next  = 1'b1;
                    out_status_next = hklp_pkg::ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_slot_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        probe_idx_reg  <= probe_idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_hash_reg   <= out_hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, entry_count_reg <= FULL_COUNT)
    `ASSERT_IMPLIES(a_pop_ready, clk, rst_n, q_pop, q_valid && !out_valid_reg)
    `ASSERT_IMPLIES(a_clear_quiet, clk, rst_n, state_reg == S_CLEAR, !out_valid_reg && !q_pop)

endmodule

// ----- rtl/core/hashed_key_linear_probe_table_core.sv -----
// top level: fnv-1a keyed hash table with linear probing
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_stall  | req_type, key_byte, byte_present, key_last, value_in
//  out     | out_valid / out_stall| status, value_out, key_digest
//
//  a key byte is taken when in_stall is low; its item with key_last queues a job
//  for the table back end, which starts a job in S_IDLE, then checks one probed slot
//  per S_CHECK step via the single read port of the slot memory; a full-table insert
//  gets ST_FULL straight from S_IDLE; a new job starts only after the previous result
//  has been taken; after reset a clearing pass empties every slot with in_stall high
//  the two-entry job queue lets bytes keep arriving while the back end probes

module hashed_key_linear_probe_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  key_byte,
    input  logic        byte_present,
    input  logic        key_last,
    input  logic [31:0] value_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [63:0] key_digest
);

    logic           push;
    hklp_pkg::job_t push_job;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    hklp_pkg::job_t q_head;
    logic           clearing;

    hklp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .key_last     (key_last),
        .value_in     (value_in),
        .q_full       (q_full),
        .clearing     (clearing),
        .push         (push),
        .push_job     (push_job)
    );

    hklp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    hklp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_job      (q_head),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .value_out  (value_out),
        .key_digest (key_digest)
    );

endmodule
